FILE: design/lfpid_pkg.sv
// Shared types, constants and the sensor error table for the line follower PID PWM driver.
`default_nettype none
package lfpid_pkg;

	localparam int ERR_W  = 11;
	localparam int INT_W  = 24;
	localparam int GAIN_W = 16;
	localparam int PROD_W = INT_W + GAIN_W + 1;
	localparam int ACC_W  = PROD_W + 1;
	localparam int TURN_W = ACC_W - GAIN_W;
	localparam int SPD_W  = TURN_W + 2;
	localparam int CIDX_W = 3;
	localparam int CDAT_W = 16;

	localparam logic [7:0]  MAX_PWM_RST  = 8'd50;
	localparam logic [7:0]  BASE_SPD_RST = 8'd17;
	localparam logic [15:0] KP_RST       = 16'd4480;
	localparam logic [15:0] KI_RST       = 16'd141;
	localparam logic [15:0] KD_RST       = 16'd666;
	localparam logic [7:0]  SPD_LIM_RST  = 8'd50;

	localparam logic [CIDX_W-1:0] REG_MAX_PWM  = 3'd0;
	localparam logic [CIDX_W-1:0] REG_BASE_SPD = 3'd1;
	localparam logic [CIDX_W-1:0] REG_KP       = 3'd2;
	localparam logic [CIDX_W-1:0] REG_KI       = 3'd3;
	localparam logic [CIDX_W-1:0] REG_KD       = 3'd4;
	localparam logic [CIDX_W-1:0] REG_SPD_LIM  = 3'd5;

	localparam logic [1:0] MUL_P = 2'd0;
	localparam logic [1:0] MUL_I = 2'd1;
	localparam logic [1:0] MUL_D = 2'd2;

	localparam logic [1:0] ACC_HOLD = 2'd0;
	localparam logic [1:0] ACC_LOAD = 2'd1;
	localparam logic [1:0] ACC_ADD  = 2'd2;

	// port bit positions
	localparam int PB_R_PWM = 0;
	localparam int PB_R_FWD = 1;
	localparam int PB_R_REV = 2;
	localparam int PB_L_PWM = 4;
	localparam int PB_L_REV = 5;
	localparam int PB_L_FWD = 6;

	typedef struct packed {
		logic [7:0]  max_pwm;
		logic [7:0]  base_speed;
		logic [15:0] prop_gain;
		logic [15:0] int_gain;
		logic [15:0] deriv_gain;
		logic [7:0]  speed_limit;
	} lfpid_cfg_t;

	typedef struct packed {
		logic       capture;
		logic       err_step;
		logic       mul_en;
		logic [1:0] mul_op;
		logic [1:0] acc_op;
		logic       trunc;
		logic       speed;
		logic       pins;
		logic       set_en;
		logic       out_load;
	} lfpid_cmd_t;

	typedef struct packed {
		logic cnt_le1;
		logic out_busy;
	} lfpid_stat_t;

	// Average of the active sensor weights in Q.8, truncated toward zero.
	function automatic logic signed [ERR_W-1:0] line_error(input logic [7:0] s);
		logic [3:0] act;
		logic signed [ERR_W-1:0] e;
		act = {s[4], ~s[7], s[3], s[5]};
		case (act)
			4'b0000: e = 11'sd0;
			4'b1000: e = -11'sd384;
			4'b0100: e = -11'sd128;
			4'b0010: e = 11'sd128;
			4'b0001: e = 11'sd384;
			4'b1100: e = -11'sd256;
			4'b1010: e = -11'sd128;
			4'b1001: e = 11'sd0;
			4'b0110: e = 11'sd0;
			4'b0101: e = 11'sd128;
			4'b0011: e = 11'sd256;
			4'b1110: e = -11'sd128;
			4'b1101: e = -11'sd42;
			4'b1011: e = 11'sd42;
			4'b0111: e = 11'sd128;
			4'b1111: e = 11'sd0;
			default: e = 11'sd0;
		endcase
		return e;
	endfunction

endpackage
`default_nettype wire

FILE: design/line_follow_pid_pwm_driver_core.sv
// Line follower PID controller with two PWM motor outputs: top level.
//
// Input stream (s_axis): one beat per event. tuser is the kind (0 timer tick,
// 1 start confirmation), tdata is the sensor status byte. Output stream
// (m_axis): one beat per input beat carrying the data port byte.
// Configuration: cfg_valid/cfg_index/cfg_data write one register per beat;
// cfg_ready is always high. Write only while no beat is in flight.
// Sequence: a tick that does not end a PWM period steps through the pin
// update only; a tick that ends a period steps through the error step, the
// three passes through the shared 24x17 multiplier, then the accumulate,
// truncate, steer and pin steps; a confirmation only sets the enable. Each
// beat then loads the output register from the done step.
// One beat is in work at a time; s_axis_tready is high only while the
// sequencer idles, so a new beat is not accepted before the last is done.
// The output register lets the next beat be accepted while a result waits;
// if m_axis_tready stays low the sequencer holds in its last step.
// Reset clears the counter, PID state, duties, port byte and the enable,
// and loads the register defaults; motors stay at zero speed until the
// first confirmation.
`default_nettype none
module line_follow_pid_pwm_driver_core (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             s_axis_tvalid,
	output logic                            s_axis_tready,
	input  wire [7:0]                       s_axis_tdata,  // [7:0] sensor_bits
	input  wire [0:0]                       s_axis_tuser,  // [0] kind
	output logic                            m_axis_tvalid,
	input  wire                             m_axis_tready,
	output logic [7:0]                      m_axis_tdata,  // [7:0] port_value
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire [lfpid_pkg::CIDX_W-1:0]     cfg_index,
	input  wire [lfpid_pkg::CDAT_W-1:0]     cfg_data
);
	import lfpid_pkg::*;

	lfpid_cfg_t  cfg;
	lfpid_cmd_t  cmd;
	lfpid_stat_t stat;

	assign cfg_ready = 1'b1;

	lfpid_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	lfpid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_kind  (s_axis_tuser[0]),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lfpid_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (cmd),
		.stat       (stat),
		.in_sensors (s_axis_tdata),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (m_axis_tdata)
	);

	// one beat in work at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while a beat is in work");

	a_right_dir: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[PB_R_FWD] && m_axis_tdata[PB_R_REV]))
		else $error("right motor driven both ways");

	a_left_dir: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[PB_L_FWD] && m_axis_tdata[PB_L_REV]))
		else $error("left motor driven both ways");
endmodule
`default_nettype wire

FILE: design/lfpid_cfg.sv
// Configuration register file of the line follower PID PWM driver.
`default_nettype none
module lfpid_cfg (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            wr_en,
	input  wire [lfpid_pkg::CIDX_W-1:0]    wr_index,
	input  wire [lfpid_pkg::CDAT_W-1:0]    wr_data,
	output lfpid_pkg::lfpid_cfg_t          cfg
);
	import lfpid_pkg::*;

	lfpid_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_pwm     <= MAX_PWM_RST;
			cfg_q.base_speed  <= BASE_SPD_RST;
			cfg_q.prop_gain   <= KP_RST;
			cfg_q.int_gain    <= KI_RST;
			cfg_q.deriv_gain  <= KD_RST;
			cfg_q.speed_limit <= SPD_LIM_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_MAX_PWM:  cfg_q.max_pwm     <= wr_data[7:0];
				REG_BASE_SPD: cfg_q.base_speed  <= wr_data[7:0];
				REG_KP:       cfg_q.prop_gain   <= wr_data;
				REG_KI:       cfg_q.int_gain    <= wr_data;
				REG_KD:       cfg_q.deriv_gain  <= wr_data;
				REG_SPD_LIM:  cfg_q.speed_limit <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule
`default_nettype wire

FILE: design/lfpid_ctrl.sv
// Sequencer that steps one item through error, PID, speed and pin update, or sets the enable.
`default_nettype none
module lfpid_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	input  wire                     in_kind,
	output logic                    in_ready,
	input  lfpid_pkg::lfpid_stat_t  stat,
	output lfpid_pkg::lfpid_cmd_t   cmd
);
	import lfpid_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_ERR   = 4'd1;
	localparam logic [3:0] ST_MUL0  = 4'd2;
	localparam logic [3:0] ST_MUL1  = 4'd3;
	localparam logic [3:0] ST_MUL2  = 4'd4;
	localparam logic [3:0] ST_ACC   = 4'd5;
	localparam logic [3:0] ST_TRUNC = 4'd6;
	localparam logic [3:0] ST_SPEED = 4'd7;
	localparam logic [3:0] ST_PINS  = 4'd8;
	localparam logic [3:0] ST_EN    = 4'd9;
	localparam logic [3:0] ST_DONE  = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_nx;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (in_kind)
						state_nx = ST_EN;
					else if (stat.cnt_le1)
						state_nx = ST_ERR;
					else
						state_nx = ST_PINS;
				end
			end
			ST_ERR: begin
				cmd.err_step = 1'b1;
				state_nx     = ST_MUL0;
			end
			ST_MUL0: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_P;
				state_nx   = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_I;
				cmd.acc_op = ACC_LOAD;
				state_nx   = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_D;
				cmd.acc_op = ACC_ADD;
				state_nx   = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc_op = ACC_ADD;
				state_nx   = ST_TRUNC;
			end
			ST_TRUNC: begin
				cmd.trunc = 1'b1;
				state_nx  = ST_SPEED;
			end
			ST_SPEED: begin
				cmd.speed = 1'b1;
				state_nx  = ST_PINS;
			end
			ST_PINS: begin
				cmd.pins = 1'b1;
				state_nx = ST_DONE;
			end
			ST_EN: begin
				cmd.set_en = 1'b1;
				state_nx   = ST_DONE;
			end
			ST_DONE: begin
				// hold until the output register is free
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nx;
	end
endmodule
`default_nettype wire

FILE: design/lfpid_dp.sv
// Datapath: PWM counter, PID arithmetic with one shared multiplier, port byte and output register.
`default_nettype none
module lfpid_dp (
	input  wire                     clk,
	input  wire                     arst_n,
	input  lfpid_pkg::lfpid_cfg_t   cfg,
	input  lfpid_pkg::lfpid_cmd_t   cmd,
	output lfpid_pkg::lfpid_stat_t  stat,
	input  wire [7:0]               in_sensors,
	output logic                    out_valid,
	input  wire                     out_ready,
	output logic [7:0]              out_data
);
	import lfpid_pkg::*;

	logic [7:0]                     sensors_q;
	logic [7:0]                     cnt_q;
	logic [7:0]                     port_q;
	logic signed [ERR_W-1:0]        prev_err_q;
	logic signed [ERR_W-1:0]        diff_q;
	logic signed [ERR_W-1:0]        err_q;
	logic signed [INT_W-1:0]        int_q;
	logic signed [PROD_W-1:0]       prod_q;
	logic signed [ACC_W-1:0]        acc_q;
	logic signed [TURN_W-1:0]       turn_q;
	logic [7:0]                     rduty_q;
	logic [7:0]                     lduty_q;
	logic                           en_q;
	logic                           oval_q;
	logic [7:0]                     odata_q;

	logic signed [ERR_W-1:0]        err_new;
	logic signed [INT_W:0]          int_sum;
	logic signed [INT_W-1:0]        int_sat;
	logic signed [INT_W-1:0]        mul_a;
	logic [GAIN_W-1:0]              mul_b;
	logic signed [PROD_W-1:0]       mul_p;
	logic signed [TURN_W-1:0]       turn_nx;
	logic signed [SPD_W-1:0]        lim;
	logic signed [SPD_W-1:0]        spd_l;
	logic signed [SPD_W-1:0]        spd_r;
	logic signed [SPD_W-1:0]        clp_l;
	logic signed [SPD_W-1:0]        clp_r;
	logic signed [SPD_W-1:0]        mag_l;
	logic signed [SPD_W-1:0]        mag_r;
	logic [7:0]                     cnt_nx;
	logic [7:0]                     port_pins;

	assign stat.cnt_le1  = (cnt_q <= 8'd1);
	assign stat.out_busy = oval_q && !out_ready;

	// error decode and saturating integral
	assign err_new = line_error(sensors_q);
	assign int_sum = {int_q[INT_W-1], int_q} + {{(INT_W+1-ERR_W){err_new[ERR_W-1]}}, err_new};
	always_comb begin
		if (int_sum[INT_W] != int_sum[INT_W-1])
			int_sat = int_sum[INT_W] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
		else
			int_sat = int_sum[INT_W-1:0];
	end

	// shared multiplier operand select
	always_comb begin
		case (cmd.mul_op)
			MUL_P: begin
				mul_a = {{(INT_W-ERR_W){err_q[ERR_W-1]}}, err_q};
				mul_b = cfg.prop_gain;
			end
			MUL_I: begin
				mul_a = int_q;
				mul_b = cfg.int_gain;
			end
			MUL_D: begin
				mul_a = {{(INT_W-ERR_W){diff_q[ERR_W-1]}}, diff_q};
				mul_b = cfg.deriv_gain;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = mul_a * $signed({1'b0, mul_b});

	// truncate Q.16 toward zero
	always_comb begin
		turn_nx = acc_q[ACC_W-1:GAIN_W];
		if (acc_q[ACC_W-1] && (acc_q[GAIN_W-1:0] != '0))
			turn_nx = turn_nx + TURN_W'(1);
	end

	// steer and clamp
	assign lim   = $signed({{(SPD_W-8){1'b0}}, cfg.speed_limit});
	assign spd_l = $signed({{(SPD_W-8){1'b0}}, cfg.base_speed})
		+ {{(SPD_W-TURN_W){turn_q[TURN_W-1]}}, turn_q};
	assign spd_r = $signed({{(SPD_W-8){1'b0}}, cfg.base_speed})
		- {{(SPD_W-TURN_W){turn_q[TURN_W-1]}}, turn_q};
	always_comb begin
		clp_l = spd_l;
		if (spd_l > lim)
			clp_l = lim;
		else if (spd_l < -lim)
			clp_l = -lim;
		clp_r = spd_r;
		if (spd_r > lim)
			clp_r = lim;
		else if (spd_r < -lim)
			clp_r = -lim;
		if (!en_q) begin
			clp_l = '0;
			clp_r = '0;
		end
		mag_l = clp_l[SPD_W-1] ? -clp_l : clp_l;
		mag_r = clp_r[SPD_W-1] ? -clp_r : clp_r;
	end

	// counter step and pin update; on wins over off
	assign cnt_nx = stat.cnt_le1 ? cfg.max_pwm : cnt_q - 8'd1;
	always_comb begin
		port_pins = port_q;
		if (cnt_nx == rduty_q)
			port_pins[PB_R_PWM] = 1'b1;
		else if (cnt_nx == cfg.max_pwm)
			port_pins[PB_R_PWM] = 1'b0;
		if (cnt_nx == lduty_q)
			port_pins[PB_L_PWM] = 1'b1;
		else if (cnt_nx == cfg.max_pwm)
			port_pins[PB_L_PWM] = 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture)
			sensors_q <= in_sensors;
		if (cmd.err_step)
			diff_q <= err_new - prev_err_q;
		if (cmd.err_step)
			err_q <= err_new;
		if (cmd.mul_en)
			prod_q <= mul_p;
		case (cmd.acc_op)
			ACC_LOAD: acc_q <= {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
			ACC_ADD:  acc_q <= acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
			default:  acc_q <= acc_q;
		endcase
		if (cmd.trunc)
			turn_q <= turn_nx;
		if (cmd.out_load)
			odata_q <= port_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			port_q     <= '0;
			prev_err_q <= '0;
			int_q      <= '0;
			rduty_q    <= '0;
			lduty_q    <= '0;
			en_q       <= 1'b0;
			oval_q     <= 1'b0;
		end else begin
			if (cmd.err_step) begin
				prev_err_q <= err_new;
				int_q      <= int_sat;
			end
			if (cmd.speed) begin
				port_q[PB_R_FWD] <= !clp_r[SPD_W-1];
				port_q[PB_R_REV] <= clp_r[SPD_W-1];
				port_q[PB_L_FWD] <= !clp_l[SPD_W-1];
				port_q[PB_L_REV] <= clp_l[SPD_W-1];
				rduty_q          <= mag_r[7:0];
				lduty_q          <= mag_l[7:0];
			end
			if (cmd.pins) begin
				cnt_q  <= cnt_nx;
				port_q <= port_pins;
			end
			if (cmd.set_en)
				en_q <= 1'b1;
			if (cmd.out_load)
				oval_q <= 1'b1;
			else if (out_ready)
				oval_q <= 1'b0;
		end
	end

	assign out_valid = oval_q;
	assign out_data  = odata_q;
endmodule
`default_nettype wire
